/* rtl/mips_segment_tlb_translate_macros.svh */
// Assertion macros shared by the segment/TLB translation RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef MIPS_SEGMENT_TLB_TRANSLATE_MACROS_SVH
`define MIPS_SEGMENT_TLB_TRANSLATE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MSTLB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MSTLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define MSTLB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/mstlb_pkg.sv */
// Shared types and constants for the segment decode / TLB translation block.
// No dependencies.
package mstlb_pkg;

  localparam int TLB_ENTRIES = 48;
  localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VPN_W       = 19;
  localparam int VPN_LSB     = 13;
  localparam int PFN_SHIFT   = 6;
  localparam int PAGE_SHIFT  = 12;
  localparam int PFN_KEEP    = 32 - PAGE_SHIFT;

  localparam logic [6:0]  ENTRY_LIMIT   = 7'(TLB_ENTRIES);
  localparam logic [2:0]  SEG_CACHED    = 3'b100;
  localparam logic [2:0]  SEG_UNCACHED  = 3'b101;
  localparam int          ODD_PAGE_BIT  = 12;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] virt_addr;
    logic [5:0]  entry_index;
    logic [31:0] entry_hi_in;
    logic [31:0] entry_mask_in;
    logic [31:0] entry_even_in;
    logic [31:0] entry_odd_in;
  } in_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        mapped;
    logic        tlb_hit;
  } out_t;

  // Entry write into the match array
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [VPN_W-1:0] vpn;
    logic [VPN_W-1:0] mask;
  } cam_wr_t;

  // Lookup result from the match array
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             entry_valid;
  } cam_res_t;

endpackage

/* rtl/mstlb_ram.sv */
// Generic single-port RAM with registered read, used for the EntryLo words.
// No dependencies.
module mstlb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 48
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mstlb_cam.sv */
// Fully associative VPN2 match array with per-entry valid bits and
// lowest-index priority select. Depends on mstlb_pkg.
module mstlb_cam (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mstlb_pkg::cam_wr_t   wr,
  input  logic [31:0]          lookup_va,
  output mstlb_pkg::cam_res_t  res
);

  import mstlb_pkg::*;

  logic [VPN_W-1:0]       vpn_r  [TLB_ENTRIES];
  logic [VPN_W-1:0]       mask_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] valid_nxt;
  logic [TLB_ENTRIES-1:0] match;
  logic [VPN_W-1:0]       va_vpn;

  assign va_vpn = lookup_va[31:VPN_LSB];

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (wr.en && (wr.idx == IDX_W'(i))) begin
        vpn_r[i]  <= wr.vpn;
        mask_r[i] <= wr.mask;
      end
    end
  end

  // Unwritten entries behave as all-zero words
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (valid_r[i]) begin
        match[i] = ((vpn_r[i] ^ va_vpn) & ~mask_r[i]) == '0;
      end else begin
        match[i] = (va_vpn == '0);
      end
    end
  end

  // Lowest index wins: scan down so the last assignment is the lowest match
  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.hit = 1'b1;
        res.idx = IDX_W'(i);
      end
    end
    res.entry_valid = valid_r[res.idx];
  end

endmodule

/* rtl/mips_segment_tlb_translate.sv */
// Top level of the segment decode / TLB translation block.
// Depends on mstlb_pkg, mstlb_cam, mstlb_ram and the assertion macro header.
//
// One transaction per cycle while the output is not stalled: each translate
// request yields one result, each entry write yields none. A translate passes
// through three registers (input, lookup, result) before its result is
// offered. The VPN2 compare of all entries and the priority select are
// combinational in the match array; the EntryLo pair of the winning entry
// comes from a single-port RAM whose read lands in the second stage. Entries
// come out of reset cleared through per-entry valid bits, so no clearing pass
// is needed and requests are accepted right after reset. Writes to an index
// beyond the table are dropped.
module mips_segment_tlb_translate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mstlb_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mstlb_pkg::out_t   out_data
);

  import mstlb_pkg::*;
  `include "mips_segment_tlb_translate_macros.svh"

  typedef struct packed {
    logic [31:0] va;
    logic        mapped;
    logic        hit;
    logic        entry_valid;
  } lookup_t;

  logic     a_valid_r;
  in_t      a_r;
  logic     b_valid_r;
  lookup_t  b_r;
  lookup_t  b_nxt;
  logic     out_valid_r;
  out_t     out_r;
  out_t     out_nxt;

  logic     a_is_write;
  logic     a_adv;
  logic     b_adv;
  logic     b_free;
  logic     out_free;
  logic     wr_in_range;
  logic     seg_direct;
  cam_wr_t  cam_wr;
  cam_res_t cam_res;
  logic     ram_we;
  logic     ram_re;
  logic [IDX_W-1:0] ram_addr;
  logic [63:0]      ram_rdata;
  logic [31:0]      lo_word;

  // Handshake chain
  assign out_free   = !out_valid_r || out_ready;
  assign b_adv      = b_valid_r && out_free;
  assign b_free     = !b_valid_r || b_adv;
  assign a_is_write = (a_r.req_type == REQ_WRITE);
  assign a_adv      = a_valid_r && (a_is_write || b_free);
  assign in_ready   = !a_valid_r || a_adv;

  // Stage A: entry writes and lookups
  assign wr_in_range = ({1'b0, a_r.entry_index} < ENTRY_LIMIT);
  assign seg_direct  = (a_r.virt_addr[31:29] == SEG_CACHED) ||
                       (a_r.virt_addr[31:29] == SEG_UNCACHED);

  always_comb begin
    cam_wr.en   = a_valid_r && a_is_write && wr_in_range;
    cam_wr.idx  = a_r.entry_index[IDX_W-1:0];
    cam_wr.vpn  = a_r.entry_hi_in[31:VPN_LSB];
    cam_wr.mask = a_r.entry_mask_in[31:VPN_LSB];
  end

  mstlb_cam u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (cam_wr),
    .lookup_va (a_r.virt_addr),
    .res       (cam_res)
  );

  assign ram_we   = cam_wr.en;
  assign ram_re   = a_valid_r && !a_is_write && b_free;
  assign ram_addr = ram_we ? cam_wr.idx : cam_res.idx;

  mstlb_ram #(
    .WIDTH (64),
    .DEPTH (TLB_ENTRIES)
  ) u_lo_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata ({a_r.entry_odd_in, a_r.entry_even_in}),
    .rdata (ram_rdata)
  );

  always_comb begin
    b_nxt.va          = a_r.virt_addr;
    b_nxt.mapped      = !seg_direct;
    b_nxt.hit         = !seg_direct && cam_res.hit;
    b_nxt.entry_valid = cam_res.entry_valid;
  end

  // Stage B: pick the EntryLo half and form the physical address
  always_comb begin
    if (!b_r.entry_valid) begin
      lo_word = '0;
    end else if (b_r.va[ODD_PAGE_BIT]) begin
      lo_word = ram_rdata[63:32];
    end else begin
      lo_word = ram_rdata[31:0];
    end

    out_nxt.mapped  = b_r.mapped;
    out_nxt.tlb_hit = b_r.hit;
    if (!b_r.mapped) begin
      out_nxt.phys_addr = {3'b000, b_r.va[28:0]};
    end else if (b_r.hit) begin
      out_nxt.phys_addr = {lo_word[PFN_SHIFT +: PFN_KEEP], b_r.va[PAGE_SHIFT-1:0]};
    end else begin
      out_nxt.phys_addr = b_r.va;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_free) begin
        b_valid_r <= ram_re;
      end
      if (out_free) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_r <= in_data;
    end
    if (ram_re) begin
      b_r <= b_nxt;
    end
    if (b_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MSTLB_ASSERT_ALWAYS(a_ram_port_excl, !(ram_we && ram_re),
    "EntryLo RAM written and read in the same cycle")
  `MSTLB_ASSERT_IMPL(a_direct_no_hit, out_valid_r && !out_r.mapped,
    !out_r.tlb_hit && (out_r.phys_addr[31:29] == 3'b000),
    "direct segment result carries a hit or a segment base")
  `MSTLB_ASSERT_NEXT(a_accept_loads_a, in_valid && in_ready, a_valid_r,
    "accepted transaction did not reach the input stage")
  `MSTLB_ASSERT_NEXT(a_write_no_result, a_valid_r && a_is_write && !b_free,
    !(b_valid_r && !$past(b_valid_r)),
    "entry write produced a lookup stage transaction")

endmodule
